>>> design/scau_pkg.sv
// shared types and constants for the spectrum channel average unit
`timescale 1ns / 1ps
`default_nettype none

package scau_pkg;

    // fixed field widths
    localparam int CH_W     = 12;
    localparam int SAMPLE_W = 32;
    localparam int MEAN_W   = 32;
    localparam int SUM_W    = 48;

    // parameter defaults
    localparam int CHANNELS_DEF    = 4096;
    localparam int MAX_SPECTRA_DEF = 65536;
    localparam int SAMPLE_BITS_DEF = 32;

    // divider retires two quotient bits per stage
    localparam int DIV_STAGES = SUM_W / 2;

    // result buffer and credit counter
    localparam int FIFO_DEPTH = 32;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int PEND_W     = $clog2(FIFO_DEPTH + 1);

    // reset value of the skip_invalid register
    localparam logic SKIP_INVALID_RST = 1'b1;

    typedef struct packed {
        logic [CH_W-1:0]            channel;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       sample_valid;
        logic                       first_spectrum;
        logic                       last_spectrum;
    } in_item_t;

    typedef struct packed {
        logic [CH_W-1:0]          out_channel;
        logic signed [MEAN_W-1:0] mean;
        logic                     mean_valid;
    } out_item_t;

endpackage

`default_nettype wire

>>> design/scau_accum.sv
// per-channel accumulator memory with read-modify-write and forwarding
`timescale 1ns / 1ps
`default_nettype none

module scau_accum #(
    parameter int CHANNELS    = scau_pkg::CHANNELS_DEF,
    parameter int MAX_SPECTRA = scau_pkg::MAX_SPECTRA_DEF,
    parameter int SAMPLE_BITS = scau_pkg::SAMPLE_BITS_DEF,
    parameter int CNT_W       = $clog2(MAX_SPECTRA + 1)
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              skip_invalid,
    input  wire logic                              item_transfer,
    input  wire scau_pkg::in_item_t                item,
    output logic                                   div_valid,
    output logic [scau_pkg::CH_W-1:0]              div_channel,
    output logic signed [scau_pkg::SUM_W-1:0]      div_sum,
    output logic [CNT_W-1:0]                       div_count,
    output logic                                   div_ok
);

    localparam int SUM_W     = scau_pkg::SUM_W;
    localparam int CLOG_CH   = (CHANNELS <= 2) ? 1 : $clog2(CHANNELS);
    localparam int ADDR_W    = (CLOG_CH > scau_pkg::CH_W) ? scau_pkg::CH_W : CLOG_CH;
    localparam int MEM_DEPTH = (CHANNELS > (1 << ADDR_W)) ? (1 << ADDR_W) : CHANNELS;
    localparam int ENT_W     = SUM_W + CNT_W + 1;
    localparam int SB        = (SAMPLE_BITS >= 32) ? 32 : SAMPLE_BITS;
    localparam int SH        = scau_pkg::SAMPLE_W - SB;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    logic [ENT_W-1:0] mem [0:MEM_DEPTH-1];
    logic [ENT_W-1:0] rd_data_reg;

    logic               s1_valid_reg;
    scau_pkg::in_item_t s1_item_reg;
    logic               s1_skip_reg;

    logic              fwd_valid_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    logic [ENT_W-1:0]  fwd_data_reg;

    logic                              div_valid_reg;
    logic [scau_pkg::CH_W-1:0]         div_channel_reg;
    logic signed [SUM_W-1:0]           div_sum_reg;
    logic [CNT_W-1:0]                  div_count_reg;
    logic                              div_ok_reg;

    logic                 in_range;
    logic [ADDR_W-1:0]    rd_addr;
    logic [ADDR_W-1:0]    s1_addr;
    logic [ENT_W-1:0]     old_ent;
    logic signed [SUM_W-1:0] base_sum;
    logic [CNT_W-1:0]     base_cnt;
    logic                 base_poison;
    logic                 new_poison;
    logic                 grow;
    logic signed [scau_pkg::SAMPLE_W-1:0] x_shl;
    logic signed [scau_pkg::SAMPLE_W-1:0] x32;
    logic signed [SUM_W:0] sum_ext;
    logic signed [SUM_W-1:0] sat_sum;
    logic signed [SUM_W-1:0] new_sum;
    logic [CNT_W-1:0]     new_cnt;
    logic [ENT_W-1:0]     new_ent;

    assign in_range = int'(item.channel) < CHANNELS;
    assign rd_addr  = item.channel[ADDR_W-1:0];
    assign s1_addr  = s1_item_reg.channel[ADDR_W-1:0];

    // accumulator memory, registered read, write-back from stage one
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
        if (s1_valid_reg)
        begin
            mem[s1_addr] <= new_ent;
        end
    end

    // stage one control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            div_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= item_transfer && in_range;
            fwd_valid_reg <= s1_valid_reg;
            div_valid_reg <= s1_valid_reg && s1_item_reg.last_spectrum;
        end
    end

    // stage one payload, forwarding copy and divider request
    always_ff @(posedge clk)
    begin
        s1_item_reg     <= item;
        s1_skip_reg     <= skip_invalid;
        fwd_addr_reg    <= s1_addr;
        fwd_data_reg    <= new_ent;
        div_channel_reg <= s1_item_reg.channel;
        div_sum_reg     <= new_sum;
        div_count_reg   <= new_cnt;
        div_ok_reg      <= (new_cnt != '0) && !new_poison;
    end

    // sign-extend the used low bits of the sample
    assign x_shl = s1_item_reg.sample <<< SH;
    assign x32   = x_shl >>> SH;

    // modify: forward last write, restart, saturating add
    always_comb
    begin
        old_ent = (fwd_valid_reg && (fwd_addr_reg == s1_addr)) ? fwd_data_reg : rd_data_reg;
        if (s1_item_reg.first_spectrum)
        begin
            base_sum    = '0;
            base_cnt    = '0;
            base_poison = 1'b0;
        end
        else
        begin
            base_sum    = old_ent[SUM_W-1:0];
            base_cnt    = old_ent[SUM_W +: CNT_W];
            base_poison = old_ent[ENT_W-1];
        end
        new_poison = base_poison || (!s1_skip_reg && !s1_item_reg.sample_valid);
        grow = (s1_item_reg.sample_valid || !s1_skip_reg)
               && (base_cnt < CNT_W'(MAX_SPECTRA));
        sum_ext = {base_sum[SUM_W-1], base_sum}
                  + {{(SUM_W + 1 - scau_pkg::SAMPLE_W){x32[scau_pkg::SAMPLE_W-1]}}, x32};
        if (sum_ext[SUM_W] != sum_ext[SUM_W-1])
        begin
            sat_sum = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            sat_sum = sum_ext[SUM_W-1:0];
        end
        new_sum = grow ? sat_sum : base_sum;
        new_cnt = grow ? base_cnt + CNT_W'(1) : base_cnt;
        new_ent = {new_poison, new_cnt, new_sum};
    end

    assign div_valid   = div_valid_reg;
    assign div_channel = div_channel_reg;
    assign div_sum     = div_sum_reg;
    assign div_count   = div_count_reg;
    assign div_ok      = div_ok_reg;

endmodule

`default_nettype wire

>>> design/scau_divider.sv
// pipelined signed-by-unsigned divider, two quotient bits per stage, saturating
`timescale 1ns / 1ps
`default_nettype none

module scau_divider #(
    parameter int CNT_W = $clog2(scau_pkg::MAX_SPECTRA_DEF + 1)
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              req_valid,
    input  wire logic [scau_pkg::CH_W-1:0]         req_channel,
    input  wire logic signed [scau_pkg::SUM_W-1:0] req_sum,
    input  wire logic [CNT_W-1:0]                  req_count,
    input  wire logic                              req_ok,
    output logic                                   res_valid,
    output scau_pkg::out_item_t                    res
);

    localparam int SUM_W  = scau_pkg::SUM_W;
    localparam int STAGES = scau_pkg::DIV_STAGES;
    localparam int MEAN_W = scau_pkg::MEAN_W;

    localparam logic [SUM_W-1:0] POS_LIM = SUM_W'({1'b0, {(MEAN_W-1){1'b1}}});
    localparam logic [SUM_W-1:0] NEG_LIM = SUM_W'({1'b1, {(MEAN_W-1){1'b0}}});

    logic                      st_valid_reg [0:STAGES];
    logic [scau_pkg::CH_W-1:0] st_chan_reg  [0:STAGES];
    logic                      st_ok_reg    [0:STAGES];
    logic                      st_neg_reg   [0:STAGES];
    logic [CNT_W-1:0]          st_div_reg   [0:STAGES];
    logic [CNT_W-1:0]          st_rem_reg   [0:STAGES];
    logic [SUM_W-1:0]          st_dq_reg    [0:STAGES];

    logic [CNT_W-1:0] rem_next [1:STAGES];
    logic [SUM_W-1:0] dq_next  [1:STAGES];

    logic                res_valid_reg;
    scau_pkg::out_item_t res_reg;
    logic [SUM_W-1:0]    q;
    logic signed [MEAN_W-1:0] mean_sat;

    // two restoring steps per stage
    always_comb
    begin
        logic [CNT_W-1:0] rem;
        logic [SUM_W-1:0] dq;
        logic [CNT_W:0]   r2;
        for (int k = 0; k < STAGES; k++)
        begin
            rem = st_rem_reg[k];
            dq  = st_dq_reg[k];
            for (int b = 0; b < 2; b++)
            begin
                r2 = {rem, dq[SUM_W-1]};
                dq = dq << 1;
                if (r2 >= {1'b0, st_div_reg[k]})
                begin
                    r2    = r2 - {1'b0, st_div_reg[k]};
                    dq[0] = 1'b1;
                end
                rem = r2[CNT_W-1:0];
            end
            rem_next[k+1] = rem;
            dq_next[k+1]  = dq;
        end
    end

    // stage valid bits and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= STAGES; k++)
            begin
                st_valid_reg[k] <= 1'b0;
            end
            res_valid_reg <= 1'b0;
        end
        else
        begin
            st_valid_reg[0] <= req_valid;
            for (int k = 1; k <= STAGES; k++)
            begin
                st_valid_reg[k] <= st_valid_reg[k-1];
            end
            res_valid_reg <= st_valid_reg[STAGES];
        end
    end

    // stage payload: magnitude prep, then iterations
    always_ff @(posedge clk)
    begin
        st_chan_reg[0] <= req_channel;
        st_ok_reg[0]   <= req_ok;
        st_neg_reg[0]  <= req_sum[SUM_W-1];
        st_div_reg[0]  <= req_count;
        st_rem_reg[0]  <= '0;
        st_dq_reg[0]   <= req_sum[SUM_W-1] ? SUM_W'(-req_sum) : SUM_W'(req_sum);
        for (int k = 1; k <= STAGES; k++)
        begin
            st_chan_reg[k] <= st_chan_reg[k-1];
            st_ok_reg[k]   <= st_ok_reg[k-1];
            st_neg_reg[k]  <= st_neg_reg[k-1];
            st_div_reg[k]  <= st_div_reg[k-1];
            st_rem_reg[k]  <= rem_next[k];
            st_dq_reg[k]   <= dq_next[k];
        end
        res_reg.out_channel <= st_chan_reg[STAGES];
        res_reg.mean        <= st_ok_reg[STAGES] ? mean_sat : '0;
        res_reg.mean_valid  <= st_ok_reg[STAGES];
    end

    // restore sign and clamp to the mean range
    assign q = st_dq_reg[STAGES];
    always_comb
    begin
        if (!st_neg_reg[STAGES])
        begin
            mean_sat = (q > POS_LIM) ? POS_LIM[MEAN_W-1:0] : q[MEAN_W-1:0];
        end
        else
        begin
            mean_sat = (q > NEG_LIM) ? NEG_LIM[MEAN_W-1:0] : -q[MEAN_W-1:0];
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

>>> design/scau_out_fifo.sv
// result buffer that decouples the divider pipeline from the receiver
`timescale 1ns / 1ps
`default_nettype none

module scau_out_fifo (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_valid,
    input  wire scau_pkg::out_item_t wr_data,
    output logic                     rd_valid,
    input  wire logic                rd_ready,
    output scau_pkg::out_item_t      rd_data
);

    scau_pkg::out_item_t               buf_reg [0:scau_pkg::FIFO_DEPTH-1];
    logic [scau_pkg::FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [scau_pkg::FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [scau_pkg::PEND_W-1:0]       count_reg;
    logic [scau_pkg::PEND_W-1:0]       count_next;
    logic                              rd_transfer;

    assign rd_valid    = count_reg != '0;
    assign rd_data     = buf_reg[rd_ptr_reg];
    assign rd_transfer = rd_valid && rd_ready;

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (wr_valid && !rd_transfer)
        begin
            count_next = count_reg + scau_pkg::PEND_W'(1);
        end
        else if (!wr_valid && rd_transfer)
        begin
            count_next = count_reg - scau_pkg::PEND_W'(1);
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + scau_pkg::FIFO_PTR_W'(1);
            end
            if (rd_transfer)
            begin
                rd_ptr_reg <= rd_ptr_reg + scau_pkg::FIFO_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_valid)
        begin
            buf_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

>>> design/spectrum_channel_average_unit.sv
// top level of the spectrum channel average unit
//
// Averages a run of spectra channel by channel. Each input transfer on the
// in channel carries one channel sample; first_spectrum restarts that
// channel's sum and count, last_spectrum makes the unit emit the channel
// mean (sum / count, truncated toward zero, clamped to 32 bits) as one
// transfer on the out channel. Other samples and samples of a channel
// index at or above CHANNELS give no result.
// Throughput: one sample per cycle while in_ready is high. The accumulator
// memory is read in the transfer cycle and written back in the next cycle;
// a back-to-back sample of the same channel takes the written value from a
// bypass register. A result passes the memory read, the accumulator stage,
// the 24-stage divider (two quotient bits per stage), the clamp register
// and the result buffer. Up to 32 results are buffered or in flight;
// in_ready falls when that credit is used up, so a stalled receiver stops
// input only after the buffer has filled, and nothing is dropped.
// The cfg channel writes skip_invalid (bit 0); write it only while idle.
// Reset sets skip_invalid to 1 and empties the pipeline and the buffer;
// the channel memory is not cleared, so the user must start every channel
// with a first_spectrum sample; the unit itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module spectrum_channel_average_unit #(
    parameter int CHANNELS    = scau_pkg::CHANNELS_DEF,
    parameter int MAX_SPECTRA = scau_pkg::MAX_SPECTRA_DEF,
    parameter int SAMPLE_BITS = scau_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire scau_pkg::in_item_t  in_item,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output scau_pkg::out_item_t      out_item,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_data
);

    localparam int CNT_W = $clog2(MAX_SPECTRA + 1);

    logic                              skip_invalid_reg;
    logic [scau_pkg::PEND_W-1:0]       pending_reg;
    logic [scau_pkg::PEND_W-1:0]       pending_next;
    logic                              in_transfer;
    logic                              needs_credit;
    logic                              out_transfer;

    logic                              div_req_valid;
    logic [scau_pkg::CH_W-1:0]         div_req_channel;
    logic signed [scau_pkg::SUM_W-1:0] div_req_sum;
    logic [CNT_W-1:0]                  div_req_count;
    logic                              div_req_ok;
    logic                              div_res_valid;
    scau_pkg::out_item_t               div_res;

    assign cfg_ready    = 1'b1;
    assign in_ready     = pending_reg < scau_pkg::PEND_W'(scau_pkg::FIFO_DEPTH);
    assign in_transfer  = in_valid && in_ready;
    assign needs_credit = in_transfer && in_item.last_spectrum
                          && (int'(in_item.channel) < CHANNELS);
    assign out_transfer = out_valid && out_ready;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_invalid_reg <= scau_pkg::SKIP_INVALID_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            skip_invalid_reg <= cfg_data;
        end
    end

    // result credit: results in flight plus buffered
    always_comb
    begin
        pending_next = pending_reg;
        if (needs_credit && !out_transfer)
        begin
            pending_next = pending_reg + scau_pkg::PEND_W'(1);
        end
        else if (!needs_credit && out_transfer)
        begin
            pending_next = pending_reg - scau_pkg::PEND_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // accumulator read-modify-write
    scau_accum #(
        .CHANNELS    (CHANNELS),
        .MAX_SPECTRA (MAX_SPECTRA),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CNT_W       (CNT_W)
    ) u_accum (
        .clk           (clk),
        .rst_n         (rst_n),
        .skip_invalid  (skip_invalid_reg),
        .item_transfer (in_transfer),
        .item          (in_item),
        .div_valid     (div_req_valid),
        .div_channel   (div_req_channel),
        .div_sum       (div_req_sum),
        .div_count     (div_req_count),
        .div_ok        (div_req_ok)
    );

    // mean divider
    scau_divider #(
        .CNT_W (CNT_W)
    ) u_divider (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (div_req_valid),
        .req_channel (div_req_channel),
        .req_sum     (div_req_sum),
        .req_count   (div_req_count),
        .req_ok      (div_req_ok),
        .res_valid   (div_res_valid),
        .res         (div_res)
    );

    // result buffer
    scau_out_fifo u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (div_res_valid),
        .wr_data  (div_res),
        .rd_valid (out_valid),
        .rd_ready (out_ready),
        .rd_data  (out_item)
    );

    // credit never exceeds the buffer depth
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= scau_pkg::PEND_W'(scau_pkg::FIFO_DEPTH))
        else $error("result credit above buffer depth");

    // a buffered result always holds a credit
    a_out_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != '0)
        else $error("result shown without credit");

    // a divider request always holds a credit
    a_div_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
        div_req_valid |-> pending_reg != '0)
        else $error("divider request without credit");

    // a credited sample reaches the accumulator stage with a credit held
    a_credit_taken: assert property (@(posedge clk) disable iff (!rst_n)
        needs_credit |=> pending_reg != '0)
        else $error("credit not taken for a result sample");

endmodule

`default_nettype wire
